// ===== design/itoa_pkg.sv =====
// Shared types, opcodes and helpers for the integer to ASCII formatter.
package itoa_pkg;

    typedef enum logic [2:0] {
        OP_SDEC = 3'd0,
        OP_UDEC = 3'd1,
        OP_LHEX = 3'd2,
        OP_UHEX = 3'd3,
        OP_PTR  = 3'd4
    } opcode_t;

    localparam int unsigned MaxChars  = 18;
    localparam int unsigned DecDigits = 10;
    localparam int unsigned MaxDigits = 16;
    localparam int unsigned BcdStages = 8;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] number;
    } in_req_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_req_t;

    // Text of one number, most significant character first.
    typedef struct packed {
        logic [MaxChars-1:0][7:0] chars;
        logic [4:0]               len;
    } text_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'd0, d};
        end else if (upper) begin
            r = 8'h41 + {4'd0, d} - 8'd10;
        end else begin
            r = 8'h61 + {4'd0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

// ===== design/itoa_bcd.sv =====
// Pipelined binary to BCD conversion, four double-dabble bits per stage.
module itoa_bcd (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         in_bin,
    input  itoa_pkg::in_req_t   in_req,
    input  logic                in_neg,
    output logic                out_valid,
    output logic [39:0]         out_bcd,
    output itoa_pkg::in_req_t   out_req,
    output logic                out_neg
);

    logic [itoa_pkg::BcdStages:0]        vld;
    logic [itoa_pkg::BcdStages:0][31:0]  bin;
    logic [itoa_pkg::BcdStages:0][39:0]  bcd;
    itoa_pkg::in_req_t                   req [itoa_pkg::BcdStages+1];
    logic [itoa_pkg::BcdStages:0]        neg;

    assign vld[0] = in_valid;
    assign bin[0] = in_bin;
    assign bcd[0] = '0;
    assign req[0] = in_req;
    assign neg[0] = in_neg;

    for (genvar s = 0; s < itoa_pkg::BcdStages; s++) begin : g_stage
        logic [31:0] bin_next;
        logic [39:0] bcd_next;
        logic        vld_reg;
        logic [31:0] bin_reg;
        logic [39:0] bcd_reg;
        itoa_pkg::in_req_t req_reg;
        logic        neg_reg;

        always_comb begin
            bin_next = bin[s];
            bcd_next = bcd[s];
            for (int b = 0; b < 4; b++) begin
                for (int d = 0; d < 10; d++) begin
                    if (bcd_next[d*4 +: 4] >= 4'd5) begin
                        bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + 4'd3;
                    end
                end
                bcd_next = {bcd_next[38:0], bin_next[31]};
                bin_next = {bin_next[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld[s];
            end
            if (en) begin
                bin_reg <= bin_next;
                bcd_reg <= bcd_next;
                req_reg <= req[s];
                neg_reg <= neg[s];
            end
        end

        assign vld[s+1] = vld_reg;
        assign bin[s+1] = bin_reg;
        assign bcd[s+1] = bcd_reg;
        assign req[s+1] = req_reg;
        assign neg[s+1] = neg_reg;
    end

    assign out_valid = vld[itoa_pkg::BcdStages];
    assign out_bcd   = bcd[itoa_pkg::BcdStages];
    assign out_req   = req[itoa_pkg::BcdStages];
    assign out_neg   = neg[itoa_pkg::BcdStages];

endmodule

// ===== design/itoa_text.sv =====
// Builds the character string of one number from its digits.
module itoa_text (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [39:0]         in_bcd,
    input  itoa_pkg::in_req_t   in_req,
    input  logic                in_neg,
    output logic                out_valid,
    output itoa_pkg::text_t     out_text
);

    logic [itoa_pkg::MaxDigits-1:0][3:0] dig;
    logic [4:0]            ndig;
    logic                  upper;
    logic                  vld_op;
    itoa_pkg::text_t       text_next;
    logic                  valid_reg;
    itoa_pkg::text_t       text_reg;
    logic [4:0]            pre;

    always_comb begin
        dig   = '0;
        ndig  = 5'd1;
        upper = 1'b0;
        pre   = 5'd0;
        text_next = '0;
        vld_op = 1'b1;
        unique case (in_req.opcode)
            itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC: begin
                for (int i = 0; i < itoa_pkg::DecDigits; i++) begin
                    dig[i] = in_bcd[i*4 +: 4];
                end
            end
            itoa_pkg::OP_LHEX, itoa_pkg::OP_UHEX: begin
                dig[7:0] = in_req.number[31:0];
                upper = (in_req.opcode == itoa_pkg::OP_UHEX);
            end
            itoa_pkg::OP_PTR: begin
                dig = in_req.number;
            end
            default: vld_op = 1'b0;
        endcase
        for (int i = 1; i < itoa_pkg::MaxDigits; i++) begin
            if (dig[i] != 4'd0) begin
                ndig = 5'(i + 1);
            end
        end
        if (in_req.opcode == itoa_pkg::OP_PTR && in_req.number == 64'd0) begin
            text_next.chars[0] = 8'h28;
            text_next.chars[1] = 8'h6e;
            text_next.chars[2] = 8'h69;
            text_next.chars[3] = 8'h6c;
            text_next.chars[4] = 8'h29;
            text_next.len = 5'd5;
        end else begin
            if (in_req.opcode == itoa_pkg::OP_PTR) begin
                text_next.chars[0] = 8'h30;
                text_next.chars[1] = 8'h78;
                pre = 5'd2;
            end else if (in_neg) begin
                text_next.chars[0] = 8'h2d;
                pre = 5'd1;
            end
            for (int k = 0; k < itoa_pkg::MaxDigits; k++) begin
                if (5'(k) < ndig) begin
                    text_next.chars[5'(k) + pre] =
                        itoa_pkg::hex_char(dig[4'(ndig - 5'(k) - 5'd1)], upper);
                end
            end
            text_next.len = pre + ndig;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid && vld_op;
        end
        if (en) begin
            text_reg <= text_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_text  = text_reg;

endmodule

// ===== design/integer_to_ascii_formatter_unit.sv =====
// Top level of the integer to ASCII formatter.
// Each request passes a ten-stage pipeline (input register, eight
// conversion stages, text build) and its text then leaves one character
// per cycle while m_ready is high, with last_char on the final one; a text
// has 1 to 18 characters, and the pipeline is held until it has all left.
// Unused opcodes give no characters.
module integer_to_ascii_formatter_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  itoa_pkg::in_req_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output itoa_pkg::out_req_t  m_data
);

    logic              en;
    logic              in_vld_reg;
    itoa_pkg::in_req_t in_req_reg;
    logic              neg;
    logic [31:0]       mag;
    logic              bcd_vld;
    logic [39:0]       bcd;
    itoa_pkg::in_req_t bcd_req;
    logic              bcd_neg;
    logic              txt_vld;
    itoa_pkg::text_t   txt;
    logic              busy_reg;
    itoa_pkg::text_t   ser_reg;
    logic [4:0]        idx_reg;
    logic              done;

    assign done = m_valid && m_ready && m_data.last_char;
    assign en = !busy_reg || done;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
        if (en) begin
            in_req_reg <= s_data;
        end
    end

    assign neg = (in_req_reg.opcode == itoa_pkg::OP_SDEC) && in_req_reg.number[31];
    assign mag = neg ? (32'd0 - in_req_reg.number[31:0]) : in_req_reg.number[31:0];

    itoa_bcd u_bcd (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(in_vld_reg), .in_bin(mag), .in_req(in_req_reg), .in_neg(neg),
        .out_valid(bcd_vld), .out_bcd(bcd), .out_req(bcd_req), .out_neg(bcd_neg)
    );

    itoa_text u_text (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(bcd_vld), .in_bcd(bcd), .in_req(bcd_req), .in_neg(bcd_neg),
        .out_valid(txt_vld), .out_text(txt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (en) begin
            busy_reg <= txt_vld;
        end
        if (en) begin
            ser_reg <= txt;
            idx_reg <= 5'd0;
        end else if (m_valid && m_ready) begin
            idx_reg <= idx_reg + 5'd1;
        end
    end

    assign m_valid = busy_reg;
    assign m_data.out_char  = ser_reg.chars[idx_reg];
    assign m_data.last_char = (idx_reg + 5'd1 == ser_reg.len);

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (ser_reg.len >= 5'd1 && ser_reg.len <= 5'(itoa_pkg::MaxChars)))
        else $error("text length out of range");
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg < ser_reg.len)
        else $error("character index past end");
    a_hold_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !done) |=> $stable(txt_vld))
        else $error("pipeline advanced during output");

endmodule
